// ----- sv/pf2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// pf2rgb_pkg
// Types and constants shared by the pixel format to RGB unit.
// ----------------------------------------------------------------------------
package pf2rgb_pkg;

  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned PalAddrW       = $clog2(PaletteEntries);
  localparam int unsigned PalIdxW        = 8;
  localparam int unsigned FmtW           = 3;

  typedef enum logic [FmtW-1:0] {
    FmtPal4   = 3'd0,
    FmtPal8   = 3'd1,
    FmtRgb565 = 3'd2,
    FmtRgb24  = 3'd3,
    FmtBgr24  = 3'd4,
    FmtBgra32 = 3'd5
  } fmt_e;

  typedef enum logic {
    KindPalWrite = 1'b0,
    KindConvert  = 1'b1
  } kind_e;

  localparam logic [FmtW-1:0] FmtReset = FmtPal8;

  localparam logic [7:0]  MaskHiNibble = 8'hF0;
  localparam logic [7:0]  MaskLoNibble = 8'h0F;
  localparam logic [15:0] MaskRed565   = 16'hF800;
  localparam logic [15:0] MaskGreen565 = 16'h07E0;
  localparam logic [15:0] MaskBlue565  = 16'h001F;

  typedef struct packed {
    logic        kind;
    logic [7:0]  palette_index;
    logic [7:0]  palette_red;
    logic [7:0]  palette_green;
    logic [7:0]  palette_blue;
    logic [31:0] pixel_word;
    logic        single;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } out_item_t;

  function automatic logic pal_in_range(logic [PalIdxW-1:0] idx);
    return {1'b0, idx} < (PalIdxW + 1)'(PaletteEntries);
  endfunction

endpackage

// ----- sv/pixel_format_to_rgb_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_format_to_rgb_unit
// Converts pal4, pal8, RGB565, RGB24, BGR24 and BGRA32 source pixels to
// 8-bit RGB. The palette sits in a synchronous memory with two read ports.
// ----------------------------------------------------------------------------
// Pipeline: the input is registered in stage s1, together with the palette
// reads, and then in the output register.
// Throughput: one item per cycle while out_stall_i is low; a pal4 pair item
// gives two results through the single output register, one per palette read,
// and stalls the input until both have left. Palette writes give no result.
// Reset: format register goes to pal8, pipeline empties; palette memory is
// not cleared and must be written before it is read.
module pixel_format_to_rgb_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  pf2rgb_pkg::in_item_t  in_item_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output pf2rgb_pkg::out_item_t out_item_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_valid_i,
  input  logic [2:0]            cfg_data_i,
  output logic                  cfg_ready_o
);
  import pf2rgb_pkg::*;

  logic [23:0] pal_mem [PaletteEntries];

  logic [FmtW-1:0] fmt_q;

  logic            s1_valid_q, s1_valid_d;
  logic            s1_pal_q;
  logic            s1_two_q;
  logic            s1_phase_q, s1_phase_d;
  logic            s1_ok0_q, s1_ok1_q;
  logic [23:0]     s1_rgb_q;
  logic [23:0]     rd0_q, rd1_q;

  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;

  logic            in_xfer, cvt_xfer, wr_xfer;
  logic            cvt_valid, cvt_pal, cvt_two;
  logic [23:0]     cvt_rgb;
  logic [PalIdxW-1:0] idx0, idx1;
  logic [15:0]     px565;
  logic [7:0]      b0, b1, b2;
  logic            out_free, s1_adv, s1_last, s1_leave;
  logic [23:0]     s1_sel;
  logic            s1_ok;

  assign cfg_ready_o = 1'b1;

  assign b0    = in_item_i.pixel_word[7:0];
  assign b1    = in_item_i.pixel_word[15:8];
  assign b2    = in_item_i.pixel_word[23:16];
  assign px565 = in_item_i.pixel_word[15:0];

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_adv   = s1_valid_q && out_free;
  assign s1_last  = !(s1_two_q && !s1_phase_q);
  assign s1_leave = s1_adv && s1_last;

  assign in_stall_o = s1_valid_q && !s1_leave;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign wr_xfer    = in_xfer && (kind_e'(in_item_i.kind) == KindPalWrite);
  assign cvt_xfer   = in_xfer && (kind_e'(in_item_i.kind) == KindConvert);

  always_comb begin
    cvt_valid = 1'b1;
    cvt_pal   = 1'b0;
    cvt_two   = 1'b0;
    cvt_rgb   = '0;
    idx0      = b0;
    idx1      = b0 & MaskLoNibble;
    unique case (fmt_q) inside
      FmtPal4: begin
        cvt_pal = 1'b1;
        cvt_two = !in_item_i.single;
        idx0    = (b0 & MaskHiNibble) >> 4;
      end
      FmtPal8: begin
        cvt_pal = 1'b1;
      end
      FmtRgb565: begin
        cvt_rgb = {5'((px565 & MaskRed565) >> 11), 3'b000,
                   6'((px565 & MaskGreen565) >> 5), 2'b00,
                   5'(px565 & MaskBlue565), 3'b000};
      end
      FmtRgb24: begin
        cvt_rgb = {b0, b1, b2};
      end
      FmtBgr24, FmtBgra32: begin
        cvt_rgb = {b2, b1, b0};
      end
      default: begin
        cvt_valid = 1'b0;
      end
    endcase
  end

  // palette memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_xfer && pal_in_range(in_item_i.palette_index)) begin
      pal_mem[in_item_i.palette_index[PalAddrW-1:0]] <=
        {in_item_i.palette_red, in_item_i.palette_green, in_item_i.palette_blue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cvt_xfer) begin
      rd0_q <= pal_mem[idx0[PalAddrW-1:0]];
      rd1_q <= pal_mem[idx1[PalAddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cvt_xfer) begin
      s1_pal_q <= cvt_pal;
      s1_two_q <= cvt_two;
      s1_ok0_q <= pal_in_range(idx0);
      s1_ok1_q <= pal_in_range(idx1);
      s1_rgb_q <= cvt_rgb;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_phase_d = s1_phase_q;
    if (s1_leave) begin
      s1_valid_d = 1'b0;
      s1_phase_d = 1'b0;
    end else if (s1_adv) begin
      s1_phase_d = 1'b1;
    end
    if (cvt_xfer && cvt_valid) begin
      s1_valid_d = 1'b1;
      s1_phase_d = 1'b0;
    end
  end

  assign s1_ok  = s1_phase_q ? s1_ok1_q : s1_ok0_q;
  assign s1_sel = !s1_pal_q ? s1_rgb_q :
                  !s1_ok    ? 24'd0    :
                  s1_phase_q ? rd1_q : rd0_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.red   <= s1_sel[23:16];
      out_q.green <= s1_sel[15:8];
      out_q.blue  <= s1_sel[7:0];
      out_q.last  <= s1_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FmtReset;
      s1_valid_q  <= 1'b0;
      s1_phase_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        fmt_q <= cfg_data_i;
      end
      s1_valid_q  <= s1_valid_d;
      s1_phase_q  <= s1_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
